[sv/dda_pkg.sv]
// ----------------------------------------------------------------------------
// DDA line rasterizer package
// Shared constants, codes and types for the line rasterizer modules.
// ----------------------------------------------------------------------------
package dda_pkg;

  localparam int unsigned COORD_BITS_DEF = 12;
  localparam int unsigned FRAC_BITS_DEF  = 16;
  localparam int unsigned REG_W          = 12;
  localparam int unsigned COLOR_W        = 32;
  localparam int unsigned CMDQ_DEPTH     = 2;

  localparam logic [REG_W-1:0] FRAME_W_RST = 12'd640;
  localparam logic [REG_W-1:0] FRAME_H_RST = 12'd480;

  typedef enum logic {
    ACT_LOAD = 1'b0,
    ACT_STEP = 1'b1
  } action_e;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_STEP = 1'b1
  } cmd_kind_e;

  typedef enum logic {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [REG_W-1:0] width;
    logic [REG_W-1:0] height;
  } frame_cfg_t;

  // Command word layout, MSB first: kind, start x, start y, inc x, inc y, step, color.
  function automatic int unsigned cmd_width(int unsigned coord_bits, int unsigned frac_bits);
    return 1 + 2 * coord_bits + 2 * (frac_bits + 2) + (coord_bits + 1) + COLOR_W;
  endfunction

endpackage

[sv/dda_cmd_if.sv]
// ----------------------------------------------------------------------------
// DDA command channel
// Valid/ready channel that carries load and step words into the rasterizer.
// ----------------------------------------------------------------------------
interface dda_cmd_if #(
  parameter int unsigned COORD_BITS = dda_pkg::COORD_BITS_DEF
) ();

  logic                          valid;
  logic                          ready;
  logic                          action;
  logic signed [COORD_BITS-1:0]  start_x;
  logic signed [COORD_BITS-1:0]  start_y;
  logic signed [COORD_BITS-1:0]  end_x;
  logic signed [COORD_BITS-1:0]  end_y;
  logic [dda_pkg::COLOR_W-1:0]   line_color;

  modport source (
    output valid, action, start_x, start_y, end_x, end_y, line_color,
    input  ready
  );

  modport sink (
    input  valid, action, start_x, start_y, end_x, end_y, line_color,
    output ready
  );

endinterface

[sv/dda_pix_if.sv]
// ----------------------------------------------------------------------------
// DDA pixel channel
// Valid/ready channel that carries rasterized pixels out of the block.
// ----------------------------------------------------------------------------
interface dda_pix_if #(
  parameter int unsigned COORD_BITS = dda_pkg::COORD_BITS_DEF
) ();

  logic                          valid;
  logic                          ready;
  logic signed [COORD_BITS-1:0]  pixel_x;
  logic signed [COORD_BITS-1:0]  pixel_y;
  logic [dda_pkg::COLOR_W-1:0]   pixel_color;
  logic                          visible;
  logic                          last;

  modport source (
    output valid, pixel_x, pixel_y, pixel_color, visible, last,
    input  ready
  );

  modport sink (
    input  valid, pixel_x, pixel_y, pixel_color, visible, last,
    output ready
  );

endinterface

[sv/dda_div.sv]
// ----------------------------------------------------------------------------
// DDA increment divider
// Two-lane restoring divider, one quotient bit per lane per cycle.
// ----------------------------------------------------------------------------
module dda_div #(
  parameter int unsigned COORD_BITS = dda_pkg::COORD_BITS_DEF,
  parameter int unsigned FRAC_BITS  = dda_pkg::FRAC_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [COORD_BITS:0]    num_x_i,
  input  logic [COORD_BITS:0]    num_y_i,
  input  logic [COORD_BITS:0]    den_i,
  output logic                   done_o,
  output logic [FRAC_BITS:0]     quo_x_o,
  output logic [FRAC_BITS:0]     quo_y_o
);

  localparam int unsigned DW = COORD_BITS + 1;
  localparam int unsigned QW = FRAC_BITS + 1;
  localparam int unsigned NW = DW + FRAC_BITS;
  localparam int unsigned CW = $clog2(NW + 1);

  logic [CW-1:0] cnt_q, cnt_d;
  logic [NW-1:0] dvd_x_q, dvd_y_q;
  logic [DW-1:0] rem_x_q, rem_y_q, den_q;
  logic [QW-1:0] quo_x_q, quo_y_q;
  logic [DW:0]   trial_x, trial_y;
  logic          ge_x, ge_y;

  assign trial_x = {rem_x_q, dvd_x_q[NW-1]};
  assign trial_y = {rem_y_q, dvd_y_q[NW-1]};
  assign ge_x    = trial_x >= {1'b0, den_q};
  assign ge_y    = trial_y >= {1'b0, den_q};

  always_comb begin
    cnt_d = cnt_q;
    if (start_i) begin
      cnt_d = CW'(NW);
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_x_q <= {num_x_i, {FRAC_BITS{1'b0}}};
      dvd_y_q <= {num_y_i, {FRAC_BITS{1'b0}}};
      den_q   <= den_i;
      rem_x_q <= '0;
      rem_y_q <= '0;
      quo_x_q <= '0;
      quo_y_q <= '0;
    end else if (cnt_q != '0) begin
      dvd_x_q <= {dvd_x_q[NW-2:0], 1'b0};
      dvd_y_q <= {dvd_y_q[NW-2:0], 1'b0};
      rem_x_q <= ge_x ? DW'(trial_x - {1'b0, den_q}) : trial_x[DW-1:0];
      rem_y_q <= ge_y ? DW'(trial_y - {1'b0, den_q}) : trial_y[DW-1:0];
      quo_x_q <= {quo_x_q[QW-2:0], ge_x};
      quo_y_q <= {quo_y_q[QW-2:0], ge_y};
    end
  end

  assign done_o  = (cnt_q == '0);
  assign quo_x_o = quo_x_q;
  assign quo_y_o = quo_y_q;

endmodule

[sv/dda_front.sv]
// ----------------------------------------------------------------------------
// DDA front end
// Accepts command words, sets up line loads through the divider and queues
// load and step commands for the back end.
// ----------------------------------------------------------------------------
module dda_front #(
  parameter int unsigned COORD_BITS = dda_pkg::COORD_BITS_DEF,
  parameter int unsigned FRAC_BITS  = dda_pkg::FRAC_BITS_DEF,
  parameter int unsigned CMD_W      = dda_pkg::cmd_width(COORD_BITS, FRAC_BITS)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  dda_cmd_if.sink          cmd_i,
  output logic             q_push_o,
  output logic [CMD_W-1:0] q_data_o,
  input  logic             q_full_i
);

  localparam int unsigned DW = COORD_BITS + 1;
  localparam int unsigned QW = FRAC_BITS + 1;
  localparam int unsigned IW = FRAC_BITS + 2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_PUSH
  } state_e;

  state_e state_q, state_d;

  logic signed [DW-1:0]         dx, dy;
  logic [DW-1:0]                mag_x, mag_y, step;
  logic                         accept, load_acc;
  logic                         div_done;
  logic [QW-1:0]                quo_x, quo_y;
  logic [IW-1:0]                qx_ext, qy_ext;
  logic signed [IW-1:0]         inc_x, inc_y;
  logic signed [COORD_BITS-1:0] sx_q, sy_q;
  logic [DW-1:0]                step_q;
  logic                         neg_x_q, neg_y_q;
  logic [dda_pkg::COLOR_W-1:0]  color_q;
  dda_pkg::cmd_kind_e           kind;

  assign dx = {cmd_i.end_x[COORD_BITS-1], cmd_i.end_x}
            - {cmd_i.start_x[COORD_BITS-1], cmd_i.start_x};
  assign dy = {cmd_i.end_y[COORD_BITS-1], cmd_i.end_y}
            - {cmd_i.start_y[COORD_BITS-1], cmd_i.start_y};
  assign mag_x = dx[DW-1] ? DW'(-dx) : DW'(dx);
  assign mag_y = dy[DW-1] ? DW'(-dy) : DW'(dy);
  assign step  = (mag_x > mag_y) ? mag_x : mag_y;

  assign cmd_i.ready = (state_q == ST_IDLE) && !q_full_i;
  assign accept      = cmd_i.valid && cmd_i.ready;
  assign load_acc    = accept && (cmd_i.action == dda_pkg::ACT_LOAD);

  dda_div #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (load_acc),
    .num_x_i (mag_x),
    .num_y_i (mag_y),
    .den_i   (step),
    .done_o  (div_done),
    .quo_x_o (quo_x),
    .quo_y_o (quo_y)
  );

  // A zero-length line gets zero increments.
  assign qx_ext = {1'b0, quo_x};
  assign qy_ext = {1'b0, quo_y};
  assign inc_x  = (step_q == '0) ? '0 : (neg_x_q ? -qx_ext : qx_ext);
  assign inc_y  = (step_q == '0) ? '0 : (neg_y_q ? -qy_ext : qy_ext);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (load_acc) begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (!q_full_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_acc) begin
      sx_q    <= cmd_i.start_x;
      sy_q    <= cmd_i.start_y;
      step_q  <= step;
      neg_x_q <= dx[DW-1];
      neg_y_q <= dy[DW-1];
      color_q <= cmd_i.line_color;
    end
  end

  assign kind     = (state_q == ST_PUSH) ? dda_pkg::CMD_LOAD : dda_pkg::CMD_STEP;
  assign q_push_o = ((state_q == ST_IDLE) && accept && (cmd_i.action == dda_pkg::ACT_STEP))
                 || ((state_q == ST_PUSH) && !q_full_i);
  assign q_data_o = {kind, sx_q, sy_q, inc_x, inc_y, step_q, color_q};

endmodule

[sv/dda_cmdq.sv]
// ----------------------------------------------------------------------------
// DDA command queue
// Small first-in first-out buffer between the front end and the back end.
// ----------------------------------------------------------------------------
module dda_cmdq #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = dda_pkg::CMDQ_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] data_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wptr_q, rptr_q;
  logic [CNT_W-1:0] count_q;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign valid_o = (count_q != '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;
  assign data_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == PTR_W'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == PTR_W'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

endmodule

[sv/dda_back.sv]
// ----------------------------------------------------------------------------
// DDA back end
// Holds the active line, steps the fixed-point position and drives the
// registered pixel output.
// ----------------------------------------------------------------------------
module dda_back #(
  parameter int unsigned COORD_BITS = dda_pkg::COORD_BITS_DEF,
  parameter int unsigned FRAC_BITS  = dda_pkg::FRAC_BITS_DEF,
  parameter int unsigned CMD_W      = dda_pkg::cmd_width(COORD_BITS, FRAC_BITS)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  input  logic [CMD_W-1:0]    q_data_i,
  output logic                q_pop_o,
  input  dda_pkg::frame_cfg_t cfg_i,
  dda_pix_if.source           pix_o
);

  localparam int unsigned DW     = COORD_BITS + 1;
  localparam int unsigned IW     = FRAC_BITS + 2;
  localparam int unsigned PW     = COORD_BITS + FRAC_BITS + 1;
  localparam int unsigned LW     = dda_pkg::REG_W + FRAC_BITS + 1;
  localparam int unsigned CMP_W  = (PW > LW) ? PW : LW;
  localparam int unsigned O_STEP = dda_pkg::COLOR_W;
  localparam int unsigned O_INCY = O_STEP + DW;
  localparam int unsigned O_INCX = O_INCY + IW;
  localparam int unsigned O_SY   = O_INCX + IW;
  localparam int unsigned O_SX   = O_SY + COORD_BITS;
  localparam int unsigned O_KIND = O_SX + COORD_BITS;

  dda_pkg::cmd_kind_e           c_kind;
  logic signed [COORD_BITS-1:0] c_sx, c_sy;
  logic signed [IW-1:0]         c_incx, c_incy;
  logic [DW-1:0]                c_step;
  logic [dda_pkg::COLOR_W-1:0]  c_color;

  logic signed [PW-1:0]         cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  logic signed [PW-1:0]         inc_x_q, inc_x_d, inc_y_q, inc_y_d;
  logic [DW-1:0]                steps_q, steps_d;
  logic [dda_pkg::COLOR_W-1:0]  color_q, color_d;
  logic                         active_q, active_d;
  logic                         out_valid_q, out_valid_d;
  logic                         out_load;

  logic [PW-1:0]                mag_x, mag_y;
  logic [COORD_BITS-1:0]        ip_x, ip_y, px, py;
  logic signed [CMP_W-1:0]      pos_x_e, pos_y_e, lim_w_e, lim_h_e;
  logic                         vis;

  logic signed [COORD_BITS-1:0] px_q, py_q;
  logic [dda_pkg::COLOR_W-1:0]  pcolor_q;
  logic                         vis_q, last_q;

  assign c_kind  = dda_pkg::cmd_kind_e'(q_data_i[O_KIND]);
  assign c_sx    = q_data_i[O_SX +: COORD_BITS];
  assign c_sy    = q_data_i[O_SY +: COORD_BITS];
  assign c_incx  = q_data_i[O_INCX +: IW];
  assign c_incy  = q_data_i[O_INCY +: IW];
  assign c_step  = q_data_i[O_STEP +: DW];
  assign c_color = q_data_i[0 +: dda_pkg::COLOR_W];

  assign q_pop_o = q_valid_i && (!out_valid_q || pix_o.ready);

  // Truncation toward zero of the fixed-point position.
  assign mag_x = cur_x_q[PW-1] ? PW'(-cur_x_q) : PW'(cur_x_q);
  assign mag_y = cur_y_q[PW-1] ? PW'(-cur_y_q) : PW'(cur_y_q);
  assign ip_x  = mag_x[FRAC_BITS +: COORD_BITS];
  assign ip_y  = mag_y[FRAC_BITS +: COORD_BITS];
  assign px    = cur_x_q[PW-1] ? -ip_x : ip_x;
  assign py    = cur_y_q[PW-1] ? -ip_y : ip_y;

  // The bounds test uses the full fixed-point position.
  assign pos_x_e = CMP_W'(cur_x_q);
  assign pos_y_e = CMP_W'(cur_y_q);
  assign lim_w_e = CMP_W'({cfg_i.width, {FRAC_BITS{1'b0}}});
  assign lim_h_e = CMP_W'({cfg_i.height, {FRAC_BITS{1'b0}}});
  assign vis     = (pos_x_e > 0) && (pos_x_e < lim_w_e)
                && (pos_y_e > 0) && (pos_y_e < lim_h_e);

  always_comb begin
    cur_x_d     = cur_x_q;
    cur_y_d     = cur_y_q;
    inc_x_d     = inc_x_q;
    inc_y_d     = inc_y_q;
    steps_d     = steps_q;
    color_d     = color_q;
    active_d    = active_q;
    out_valid_d = out_valid_q && !pix_o.ready;
    out_load    = 1'b0;
    if (q_pop_o) begin
      if (c_kind == dda_pkg::CMD_LOAD) begin
        cur_x_d  = PW'(c_sx) <<< FRAC_BITS;
        cur_y_d  = PW'(c_sy) <<< FRAC_BITS;
        inc_x_d  = PW'(c_incx);
        inc_y_d  = PW'(c_incy);
        steps_d  = c_step;
        color_d  = c_color;
        active_d = 1'b1;
      end else if (active_q) begin
        out_load    = 1'b1;
        out_valid_d = 1'b1;
        if (steps_q == '0) begin
          active_d = 1'b0;
        end else begin
          cur_x_d = cur_x_q + inc_x_q;
          cur_y_d = cur_y_q + inc_y_q;
          steps_d = steps_q - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      active_q    <= active_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_x_q <= cur_x_d;
    cur_y_q <= cur_y_d;
    inc_x_q <= inc_x_d;
    inc_y_q <= inc_y_d;
    steps_q <= steps_d;
    color_q <= color_d;
    if (out_load) begin
      px_q     <= px;
      py_q     <= py;
      pcolor_q <= color_q;
      vis_q    <= vis;
      last_q   <= (steps_q == '0);
    end
  end

  assign pix_o.valid       = out_valid_q;
  assign pix_o.pixel_x     = px_q;
  assign pix_o.pixel_y     = py_q;
  assign pix_o.pixel_color = pcolor_q;
  assign pix_o.visible     = vis_q;
  assign pix_o.last        = last_q;

endmodule

[sv/dda_line_rasterizer.sv]
// ----------------------------------------------------------------------------
// DDA line rasterizer
// A step word passes through the command queue and the pixel output register before
// its pixel shows; steps run at one per cycle while the pixel output is not stalled.
// A load word holds the input until the bit-serial divider has formed both axis
// increments. Reset clears the queue, the active line and the output valid; the frame
// size returns to 640 by 480.
// ----------------------------------------------------------------------------
module dda_line_rasterizer #(
  parameter int unsigned COORD_BITS = dda_pkg::COORD_BITS_DEF,
  parameter int unsigned FRAC_BITS  = dda_pkg::FRAC_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  dda_cmd_if.sink                   cmd_i,
  dda_pix_if.source                 pix_o,
  input  logic                      cfg_we_i,
  input  logic                      cfg_idx_i,
  input  logic [dda_pkg::REG_W-1:0] cfg_wdata_i
);

  localparam int unsigned CMD_W = dda_pkg::cmd_width(COORD_BITS, FRAC_BITS);

  dda_pkg::frame_cfg_t cfg_q;
  logic                q_push, q_full, q_valid, q_pop;
  logic [CMD_W-1:0]    q_wdata, q_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.width  <= dda_pkg::FRAME_W_RST;
      cfg_q.height <= dda_pkg::FRAME_H_RST;
    end else if (cfg_we_i) begin
      unique case (dda_pkg::cfg_reg_e'(cfg_idx_i))
        dda_pkg::REG_FRAME_WIDTH:  cfg_q.width  <= cfg_wdata_i;
        dda_pkg::REG_FRAME_HEIGHT: cfg_q.height <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  dda_front #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS),
    .CMD_W      (CMD_W)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd_i),
    .q_push_o (q_push),
    .q_data_o (q_wdata),
    .q_full_i (q_full)
  );

  dda_cmdq #(
    .WIDTH (CMD_W),
    .DEPTH (dda_pkg::CMDQ_DEPTH)
  ) u_cmdq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_rdata)
  );

  dda_back #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS),
    .CMD_W      (CMD_W)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_data_i  (q_rdata),
    .q_pop_o   (q_pop),
    .cfg_i     (cfg_q),
    .pix_o     (pix_o)
  );

endmodule

[sv/dda_checker.sv]
// ----------------------------------------------------------------------------
// DDA port checker
// Watches the rasterizer ports and flags behavior that breaks its contract.
// ----------------------------------------------------------------------------
module dda_checker #(
  parameter int unsigned COORD_BITS = dda_pkg::COORD_BITS_DEF
) (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        cmd_valid_i,
  input logic                        cmd_ready_i,
  input logic                        cmd_action_i,
  input logic                        pix_valid_i,
  input logic                        pix_ready_i,
  input logic [COORD_BITS-1:0]       pix_x_i,
  input logic [COORD_BITS-1:0]       pix_y_i,
  input logic [dda_pkg::COLOR_W-1:0] pix_color_i,
  input logic                        pix_visible_i,
  input logic                        pix_last_i
);

  logic load_acc;
  logic loaded_q;

  assign load_acc = cmd_valid_i && cmd_ready_i && (cmd_action_i == dda_pkg::ACT_LOAD);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loaded_q <= 1'b0;
    end else if (load_acc) begin
      loaded_q <= 1'b1;
    end
  end

  a_pix_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix_valid_i && !pix_ready_i |=> pix_valid_i
      && $stable({pix_x_i, pix_y_i, pix_color_i, pix_visible_i, pix_last_i}))
    else $error("Stalled pixel word changed or dropped.");

  a_pix_after_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix_valid_i |-> loaded_q)
    else $error("Pixel word shown before any line was loaded.");

  a_visible_nonneg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix_valid_i && pix_visible_i |-> !pix_x_i[COORD_BITS-1] && !pix_y_i[COORD_BITS-1])
    else $error("Visible pixel has a negative coordinate.");

  a_load_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_acc |=> !cmd_ready_i)
    else $error("Command channel ready while a load is being divided.");

endmodule

bind dda_line_rasterizer dda_checker #(
  .COORD_BITS (COORD_BITS)
) u_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .cmd_valid_i   (cmd_i.valid),
  .cmd_ready_i   (cmd_i.ready),
  .cmd_action_i  (cmd_i.action),
  .pix_valid_i   (pix_o.valid),
  .pix_ready_i   (pix_o.ready),
  .pix_x_i       (pix_o.pixel_x),
  .pix_y_i       (pix_o.pixel_y),
  .pix_color_i   (pix_o.pixel_color),
  .pix_visible_i (pix_o.visible),
  .pix_last_i    (pix_o.last)
);
